@@ design/mrc_pkg.sv @@
// Package: event codes, saturation limits and the saturating accumulate for the mouse report coalescer.
package mrc_pkg;

    localparam int unsigned ACC_W    = 8;
    localparam int unsigned MOVE_W   = 16;
    localparam int unsigned SCROLL_W = 8;
    localparam int unsigned TIME_W   = 48;
    localparam int unsigned IVAL_W   = 16;
    localparam int unsigned SUM_W    = MOVE_W + 1;

    localparam logic signed [SUM_W-1:0] SAT_HI = 17'sd127;
    localparam logic signed [SUM_W-1:0] SAT_LO = -17'sd127;

    localparam logic [IVAL_W-1:0] INTERVAL_RESET = 16'd1000;

    typedef enum logic [1:0] {
        FUNC_MOVE   = 2'd0,
        FUNC_SCROLL = 2'd1,
        FUNC_BUTTON = 2'd2
    } func_t;

    // Add a 16-bit delta to an 8-bit accumulator exactly, then clamp to +/-127
    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0]  acc,
        input logic signed [MOVE_W-1:0] delta
    );
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] res;
        sum = {{(SUM_W-ACC_W){acc[ACC_W-1]}}, acc} + {delta[MOVE_W-1], delta};
        res = sum;
        if (sum > SAT_HI)
        begin
            res = SAT_HI;
        end
        if (sum < SAT_LO)
        begin
            res = SAT_LO;
        end
        return res[ACC_W-1:0];
    endfunction

endpackage

@@ design/mouse_report_coalescer.sv @@
// Top level: mouse event accumulation and rate-limited report generation.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------------
//  in      | input     | in_valid / in_ready    | func, move_x/y, scroll_*, button_mask,
//          |           |                        | pressed, host_ready, time_us
//  out     | output    | out_valid / out_ready  | report_buttons, report_dx/dy/vscroll/hscroll
//  cfg     | input     | cfg_valid / cfg_ready  | cfg_data (min_interval_us), always ready
//
// One event per cycle when no output stall holds it: an event lands in the input register, is
// resolved there against the accumulator state and any report is registered in the output
// register. The 48-bit elapsed-time subtract sets the critical path. An output stall holds
// the evaluate stage and the input register, so in_ready stays low until the waiting report
// transfers. Reset clears the valid flags and accumulator state and loads the 1000 us interval.
module mouse_report_coalescer
    import mrc_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  func,
    input  logic signed [MOVE_W-1:0]    move_x,
    input  logic signed [MOVE_W-1:0]    move_y,
    input  logic signed [SCROLL_W-1:0]  scroll_vert,
    input  logic signed [SCROLL_W-1:0]  scroll_horiz,
    input  logic [7:0]                  button_mask,
    input  logic                        pressed,
    input  logic                        host_ready,
    input  logic [TIME_W-1:0]           time_us,

    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  report_buttons,
    output logic signed [ACC_W-1:0]     report_dx,
    output logic signed [ACC_W-1:0]     report_dy,
    output logic signed [ACC_W-1:0]     report_vscroll,
    output logic signed [ACC_W-1:0]     report_hscroll,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [IVAL_W-1:0]           cfg_data
);

    // Input register
    logic                       in_valid_reg;
    logic [1:0]                 func_reg;
    logic signed [MOVE_W-1:0]   move_x_reg;
    logic signed [MOVE_W-1:0]   move_y_reg;
    logic signed [SCROLL_W-1:0] scroll_vert_reg;
    logic signed [SCROLL_W-1:0] scroll_horiz_reg;
    logic [7:0]                 button_mask_reg;
    logic                       pressed_reg;
    logic                       host_ready_reg;
    logic [TIME_W-1:0]          time_reg;

    // Accumulator state
    logic [IVAL_W-1:0]          min_interval_reg;
    logic signed [ACC_W-1:0]    pend_x_reg;
    logic signed [ACC_W-1:0]    pend_y_reg;
    logic signed [ACC_W-1:0]    pend_vwheel_reg;
    logic signed [ACC_W-1:0]    pend_hwheel_reg;
    logic [7:0]                 cur_buttons_reg;
    logic [7:0]                 sent_buttons_reg;
    logic [TIME_W-1:0]          last_sent_time_reg;

    // Output register
    logic                       out_valid_reg;
    logic [7:0]                 rpt_buttons_reg;
    logic signed [ACC_W-1:0]    rpt_dx_reg;
    logic signed [ACC_W-1:0]    rpt_dy_reg;
    logic signed [ACC_W-1:0]    rpt_vscroll_reg;
    logic signed [ACC_W-1:0]    rpt_hscroll_reg;

    // Evaluate-stage results
    logic signed [ACC_W-1:0]    pend_x_next;
    logic signed [ACC_W-1:0]    pend_y_next;
    logic signed [ACC_W-1:0]    pend_vwheel_next;
    logic signed [ACC_W-1:0]    pend_hwheel_next;
    logic [7:0]                 cur_buttons_next;
    logic                       known_event;
    logic                       is_repeat;
    logic [TIME_W-1:0]          elapsed;
    logic                       too_soon;
    logic                       fire;
    logic                       out_free;
    logic                       stage_go;

    // Advance the stage only when the output register can take its result
    assign out_free  = !out_valid_reg || out_ready;
    assign stage_go  = in_valid_reg && out_free;
    assign in_ready  = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;

    // Apply the event to the pending state
    always_comb
    begin
        pend_x_next      = pend_x_reg;
        pend_y_next      = pend_y_reg;
        pend_vwheel_next = pend_vwheel_reg;
        pend_hwheel_next = pend_hwheel_reg;
        cur_buttons_next = cur_buttons_reg;
        known_event      = 1'b1;
        unique case (func_reg)
            FUNC_MOVE:
            begin
                pend_x_next = sat_add(pend_x_reg, move_x_reg);
                pend_y_next = sat_add(pend_y_reg, move_y_reg);
            end
            FUNC_SCROLL:
            begin
                pend_vwheel_next = sat_add(pend_vwheel_reg,
                    {{(MOVE_W-SCROLL_W){scroll_vert_reg[SCROLL_W-1]}}, scroll_vert_reg});
                pend_hwheel_next = sat_add(pend_hwheel_reg,
                    {{(MOVE_W-SCROLL_W){scroll_horiz_reg[SCROLL_W-1]}}, scroll_horiz_reg});
            end
            FUNC_BUTTON:
            begin
                if (pressed_reg)
                begin
                    cur_buttons_next = cur_buttons_reg | button_mask_reg;
                end
                else
                begin
                    cur_buttons_next = cur_buttons_reg & ~button_mask_reg;
                end
            end
            default:
            begin
                known_event = 1'b0;
            end
        endcase
    end

    // Decide whether a report goes out
    assign is_repeat = (cur_buttons_next == sent_buttons_reg) &&
                       (pend_x_next == '0) && (pend_y_next == '0) &&
                       (pend_vwheel_next == '0) && (pend_hwheel_next == '0);
    assign elapsed   = time_reg - last_sent_time_reg;
    assign too_soon  = (elapsed[TIME_W-1:IVAL_W] == '0) &&
                       (elapsed[IVAL_W-1:0] < min_interval_reg);
    assign fire      = known_event && host_ready_reg && !is_repeat && !too_soon;

    // Capture input events
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            func_reg         <= func;
            move_x_reg       <= move_x;
            move_y_reg       <= move_y;
            scroll_vert_reg  <= scroll_vert;
            scroll_horiz_reg <= scroll_horiz;
            button_mask_reg  <= button_mask;
            pressed_reg      <= pressed;
            host_ready_reg   <= host_ready;
            time_reg         <= time_us;
        end
    end

    // Update configuration and accumulator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_interval_reg   <= INTERVAL_RESET;
            pend_x_reg         <= '0;
            pend_y_reg         <= '0;
            pend_vwheel_reg    <= '0;
            pend_hwheel_reg    <= '0;
            cur_buttons_reg    <= '0;
            sent_buttons_reg   <= '0;
            last_sent_time_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                min_interval_reg <= cfg_data;
            end
            if (stage_go)
            begin
                cur_buttons_reg <= cur_buttons_next;
                if (fire)
                begin
                    pend_x_reg         <= '0;
                    pend_y_reg         <= '0;
                    pend_vwheel_reg    <= '0;
                    pend_hwheel_reg    <= '0;
                    sent_buttons_reg   <= cur_buttons_next;
                    last_sent_time_reg <= time_reg;
                end
                else
                begin
                    pend_x_reg      <= pend_x_next;
                    pend_y_reg      <= pend_y_next;
                    pend_vwheel_reg <= pend_vwheel_next;
                    pend_hwheel_reg <= pend_hwheel_next;
                end
            end
        end
    end

    // Hold the report until its transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= stage_go && fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_go && fire)
        begin
            rpt_buttons_reg <= cur_buttons_next;
            rpt_dx_reg      <= pend_x_next;
            rpt_dy_reg      <= pend_y_next;
            rpt_vscroll_reg <= pend_vwheel_next;
            rpt_hscroll_reg <= pend_hwheel_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign report_buttons = rpt_buttons_reg;
    assign report_dx      = rpt_dx_reg;
    assign report_dy      = rpt_dy_reg;
    assign report_vscroll = rpt_vscroll_reg;
    assign report_hscroll = rpt_hscroll_reg;

endmodule

@@ test/mrc_checker.sv @@
// Checker for the mouse report coalescer: predicts reports from input transfers and compares.
`timescale 1ns / 1ps

module mrc_checker
    import mrc_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [1:0]                  func,
    input  logic signed [MOVE_W-1:0]    move_x,
    input  logic signed [MOVE_W-1:0]    move_y,
    input  logic signed [SCROLL_W-1:0]  scroll_vert,
    input  logic signed [SCROLL_W-1:0]  scroll_horiz,
    input  logic [7:0]                  button_mask,
    input  logic                        pressed,
    input  logic                        host_ready,
    input  logic [TIME_W-1:0]           time_us,

    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [7:0]                  report_buttons,
    input  logic signed [ACC_W-1:0]     report_dx,
    input  logic signed [ACC_W-1:0]     report_dy,
    input  logic signed [ACC_W-1:0]     report_vscroll,
    input  logic signed [ACC_W-1:0]     report_hscroll,

    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [IVAL_W-1:0]           cfg_data,

    output int                          fail_count,
    output int                          expected_left
);

    localparam int ACC_MAX = 127;
    localparam int ACC_MIN = -127;

    typedef struct packed {
        logic [7:0]              buttons;
        logic signed [ACC_W-1:0] dx;
        logic signed [ACC_W-1:0] dy;
        logic signed [ACC_W-1:0] vscroll;
        logic signed [ACC_W-1:0] hscroll;
    } report_t;

    // Shadow copy of the coalescer state
    logic [IVAL_W-1:0]       interval_us;
    logic signed [ACC_W-1:0] motion_x;
    logic signed [ACC_W-1:0] motion_y;
    logic signed [ACC_W-1:0] wheel_v;
    logic signed [ACC_W-1:0] wheel_h;
    logic [7:0]              held_buttons;
    logic [7:0]              sent_buttons;
    logic [TIME_W-1:0]       sent_time;

    report_t                 pending_reports[$];

    // Accumulate exactly, then clamp to the symmetric 8-bit range
    function automatic logic signed [ACC_W-1:0] clamp_add(
        input logic signed [ACC_W-1:0] acc,
        input int                      delta
    );
        int total;
        total = int'(acc) + delta;
        if (total > ACC_MAX)
        begin
            total = ACC_MAX;
        end
        else if (total < ACC_MIN)
        begin
            total = ACC_MIN;
        end
        return total[ACC_W-1:0];
    endfunction

    // Apply one event to the shadow state and queue the report it triggers, if any
    task automatic coalesce_event();
        logic [TIME_W-1:0] elapsed;
        report_t           rpt;
        case (func)
            FUNC_MOVE:
            begin
                motion_x = clamp_add(motion_x, int'(move_x));
                motion_y = clamp_add(motion_y, int'(move_y));
            end
            FUNC_SCROLL:
            begin
                wheel_v = clamp_add(wheel_v, int'(scroll_vert));
                wheel_h = clamp_add(wheel_h, int'(scroll_horiz));
            end
            FUNC_BUTTON:
            begin
                if (pressed)
                begin
                    held_buttons = held_buttons | button_mask;
                end
                else
                begin
                    held_buttons = held_buttons & ~button_mask;
                end
            end
            default:
            begin
                return;
            end
        endcase

        // Hold back when the host is busy, nothing changed, or the interval is short
        if (!host_ready)
        begin
            return;
        end
        if (held_buttons == sent_buttons && motion_x == 0 && motion_y == 0 &&
            wheel_v == 0 && wheel_h == 0)
        begin
            return;
        end
        elapsed = time_us - sent_time;
        if (elapsed < {{(TIME_W-IVAL_W){1'b0}}, interval_us})
        begin
            return;
        end

        rpt.buttons = held_buttons;
        rpt.dx      = motion_x;
        rpt.dy      = motion_y;
        rpt.vscroll = wheel_v;
        rpt.hscroll = wheel_h;
        pending_reports.push_back(rpt);

        motion_x     = '0;
        motion_y     = '0;
        wheel_v      = '0;
        wheel_h      = '0;
        sent_buttons = held_buttons;
        sent_time    = time_us;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Compare one report transfer against the oldest prediction
    task automatic check_report();
        report_t want;
        if (pending_reports.size() == 0)
        begin
            $display("%0t: unexpected report, expected none, got buttons %0h dx %0d dy %0d",
                     $time, report_buttons, report_dx, report_dy);
            fail_count++;
            return;
        end
        want = pending_reports.pop_front();
        check_field("report_buttons", int'(want.buttons), int'(report_buttons));
        check_field("report_dx", int'(want.dx), int'(report_dx));
        check_field("report_dy", int'(want.dy), int'(report_dy));
        check_field("report_vscroll", int'(want.vscroll), int'(report_vscroll));
        check_field("report_hscroll", int'(want.hscroll), int'(report_hscroll));
    endtask

    // Retire reports first: a report never comes from the event of the same edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_us   = INTERVAL_RESET;
            motion_x      = '0;
            motion_y      = '0;
            wheel_v       = '0;
            wheel_h       = '0;
            held_buttons  = '0;
            sent_buttons  = '0;
            sent_time     = '0;
            pending_reports.delete();
            fail_count    = 0;
            expected_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                check_report();
            end
            if (cfg_valid && cfg_ready)
            begin
                interval_us = cfg_data;
            end
            if (in_valid && in_ready)
            begin
                coalesce_event();
            end
            expected_left = pending_reports.size();
        end
    end

endmodule

@@ test/testbench.sv @@
// Testbench top: drives mouse events and interval writes into the coalescer and reports the verdict.
`timescale 1ns / 1ps

module testbench;
    import mrc_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int         PHASE_ITEMS = 250;
    localparam int         DRAIN_CYCLES = 8;

    logic                        clk;
    logic                        rst_n;

    logic                        in_valid;
    logic                        in_ready;
    logic [1:0]                  func;
    logic signed [MOVE_W-1:0]    move_x;
    logic signed [MOVE_W-1:0]    move_y;
    logic signed [SCROLL_W-1:0]  scroll_vert;
    logic signed [SCROLL_W-1:0]  scroll_horiz;
    logic [7:0]                  button_mask;
    logic                        pressed;
    logic                        host_ready;
    logic [TIME_W-1:0]           time_us;

    logic                        out_valid;
    logic                        out_ready;
    logic [7:0]                  report_buttons;
    logic signed [ACC_W-1:0]     report_dx;
    logic signed [ACC_W-1:0]     report_dy;
    logic signed [ACC_W-1:0]     report_vscroll;
    logic signed [ACC_W-1:0]     report_hscroll;

    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [IVAL_W-1:0]           cfg_data;

    int                          fail_count;
    int                          expected_left;

    // Idle knobs: zero gives back-to-back traffic
    int                          gap_max;
    int                          stall_max;
    int                          cur_interval;
    logic [TIME_W-1:0]           now_us;

    mouse_report_coalescer i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .move_x         (move_x),
        .move_y         (move_y),
        .scroll_vert    (scroll_vert),
        .scroll_horiz   (scroll_horiz),
        .button_mask    (button_mask),
        .pressed        (pressed),
        .host_ready     (host_ready),
        .time_us        (time_us),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .report_buttons (report_buttons),
        .report_dx      (report_dx),
        .report_dy      (report_dy),
        .report_vscroll (report_vscroll),
        .report_hscroll (report_hscroll),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    mrc_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .move_x         (move_x),
        .move_y         (move_y),
        .scroll_vert    (scroll_vert),
        .scroll_horiz   (scroll_horiz),
        .button_mask    (button_mask),
        .pressed        (pressed),
        .host_ready     (host_ready),
        .time_us        (time_us),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .report_buttons (report_buttons),
        .report_dx      (report_dx),
        .report_dy      (report_dy),
        .report_vscroll (report_vscroll),
        .report_hscroll (report_hscroll),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .expected_left  (expected_left)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Present one event after a random gap and hold it until the transfer
    task automatic send_event(
        input logic [1:0]                 f,
        input logic signed [MOVE_W-1:0]   mx,
        input logic signed [MOVE_W-1:0]   my,
        input logic signed [SCROLL_W-1:0] sv,
        input logic signed [SCROLL_W-1:0] sh,
        input logic [7:0]                 mask,
        input logic                       prs,
        input logic                       rdy,
        input logic [TIME_W-1:0]          t
    );
        int gap;
        gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        func         = f;
        move_x       = mx;
        move_y       = my;
        scroll_vert  = sv;
        scroll_horiz = sh;
        button_mask  = mask;
        pressed      = prs;
        host_ready   = rdy;
        time_us      = t;
        in_valid     = 1'b1;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Mostly well-formed events with a forward-running clock, some noise
    task automatic send_random_event();
        int                         pick;
        int                         adv;
        logic [1:0]                 f;
        logic signed [MOVE_W-1:0]   mx;
        logic signed [MOVE_W-1:0]   my;
        logic signed [SCROLL_W-1:0] sv;
        logic signed [SCROLL_W-1:0] sh;
        logic [7:0]                 mask;
        logic                       prs;
        logic                       rdy;
        pick = $urandom_range(99, 0);
        mx   = MOVE_W'($urandom);
        my   = MOVE_W'($urandom);
        sv   = SCROLL_W'($urandom);
        sh   = SCROLL_W'($urandom);
        mask = 8'($urandom);
        prs  = 1'($urandom);
        rdy  = ($urandom_range(9, 0) != 0);
        if (pick < 5)
        begin
            f      = 2'($urandom);
            now_us = TIME_W'({$urandom, $urandom});
        end
        else
        begin
            if (pick < 45)
            begin
                f = FUNC_MOVE;
            end
            else if (pick < 65)
            begin
                f = FUNC_SCROLL;
            end
            else
            begin
                f = FUNC_BUTTON;
            end
            if ($urandom_range(7, 0) != 0)
            begin
                mx = MOVE_W'(int'($urandom_range(400, 0)) - 200);
                my = MOVE_W'(int'($urandom_range(400, 0)) - 200);
                sv = SCROLL_W'(int'($urandom_range(4, 0)) - 2);
                sh = SCROLL_W'(int'($urandom_range(4, 0)) - 2);
            end
            adv    = $urandom_range(cur_interval + 16, 0);
            now_us = now_us + TIME_W'(adv);
        end
        send_event(f, mx, my, sv, sh, mask, prs, rdy, now_us);
    endtask

    // Drop valid, drain every predicted report, then let the pipeline settle
    task automatic wait_idle();
        in_valid = 1'b0;
        while (expected_left != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_interval(input logic [IVAL_W-1:0] value);
        wait_idle();
        cfg_data  = value;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Report sink: random stall before each transfer
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(negedge clk);
        forever
        begin
            stall = (stall_max == 0) ? 0 : $urandom_range(stall_max, 0);
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            @(posedge clk);
            while (!out_valid)
            begin
                @(posedge clk);
            end
            @(negedge clk);
        end
    end

    // Stimulus and verdict
    initial
    begin
        int ival;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        func         = FUNC_MOVE;
        move_x       = '0;
        move_y       = '0;
        scroll_vert  = '0;
        scroll_horiz = '0;
        button_mask  = '0;
        pressed      = 1'b0;
        host_ready   = 1'b0;
        time_us      = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        gap_max      = 19;
        stall_max    = 19;
        cur_interval = int'(INTERVAL_RESET);
        now_us       = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Interval hold-off at reset value, then saturating motion
        send_event(FUNC_MOVE, 16'sh7FFF, 16'sh8000, 8'sh00, 8'sh00, 8'h00, 1'b0, 1'b1,
                   48'd500);
        send_event(FUNC_MOVE, 16'sh7FFF, 16'sh8000, 8'sh00, 8'sh00, 8'h00, 1'b0, 1'b1,
                   48'd1000);
        send_event(FUNC_SCROLL, 16'sh0000, 16'sh0000, 8'sh7F, 8'sh80, 8'h00, 1'b0, 1'b1,
                   48'd1200);
        send_event(FUNC_SCROLL, 16'sh0000, 16'sh0000, 8'sh80, 8'sh7F, 8'h00, 1'b0, 1'b0,
                   48'd2500);
        send_event(FUNC_BUTTON, 16'sh0000, 16'sh0000, 8'sh00, 8'sh00, 8'hFF, 1'b1, 1'b1,
                   48'd2500);
        // Repeat without motion, then a release
        send_event(FUNC_BUTTON, 16'sh0000, 16'sh0000, 8'sh00, 8'sh00, 8'h00, 1'b1, 1'b1,
                   48'd5000);
        send_event(FUNC_BUTTON, 16'sh0000, 16'sh0000, 8'sh00, 8'sh00, 8'h0F, 1'b0, 1'b1,
                   48'd5000);
        // Unused event kind with every field at its top
        send_event(FUNC_UNUSED, 16'shFFFF, 16'shFFFF, 8'shFF, 8'shFF, 8'hFF, 1'b1, 1'b1,
                   48'd9000);
        send_event(FUNC_MOVE, 16'shFFFF, 16'sh0001, 8'sh00, 8'sh00, 8'h00, 1'b0, 1'b1,
                   48'd9000);
        // Foreign fields set, interval one short, then exactly met
        send_event(FUNC_MOVE, 16'sh8000, 16'sh7FFF, 8'sh7F, 8'sh7F, 8'hFF, 1'b1, 1'b1,
                   48'd9999);
        send_event(FUNC_MOVE, 16'sh0001, 16'shFFFF, 8'sh80, 8'sh80, 8'hFF, 1'b0, 1'b1,
                   48'd10000);
        // Timer wrap
        send_event(FUNC_SCROLL, 16'sh0000, 16'sh0000, 8'sh05, 8'shFB, 8'h00, 1'b0, 1'b1,
                   48'hFFFF_FFFF_FFFF);
        send_event(FUNC_MOVE, 16'sh0003, 16'sh0003, 8'sh00, 8'sh00, 8'h00, 1'b0, 1'b1,
                   48'd998);
        send_event(FUNC_MOVE, 16'sh0000, 16'sh0000, 8'sh00, 8'sh00, 8'h00, 1'b0, 1'b1,
                   48'd999);
        send_event(FUNC_BUTTON, 16'sh0000, 16'sh0000, 8'sh00, 8'sh00, 8'hF0, 1'b0, 1'b0,
                   48'd5000);
        send_event(FUNC_BUTTON, 16'sh0000, 16'sh0000, 8'sh00, 8'sh00, 8'h00, 1'b0, 1'b1,
                   48'd5000);

        // Random phases across interval settings and idle patterns
        now_us = 48'd20000;
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:       ival = 0;
                1:       ival = 65535;
                2:       ival = 1;
                5:       ival = int'(INTERVAL_RESET);
                default: ival = $urandom_range(5000, 2);
            endcase
            case (p)
                1:
                begin
                    gap_max   = 0;
                    stall_max = 19;
                end
                3:
                begin
                    gap_max   = 0;
                    stall_max = 0;
                end
                4:
                begin
                    gap_max   = 19;
                    stall_max = 0;
                end
                default:
                begin
                    gap_max   = 19;
                    stall_max = 19;
                end
            endcase
            write_interval(IVAL_W'(ival));
            cur_interval = ival;
            repeat (PHASE_ITEMS) send_random_event();
        end

        wait_idle();
        if (fail_count == 0 && expected_left == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

@@ mouse_report_coalescer.f @@
design/mrc_pkg.sv
design/mouse_report_coalescer.sv
test/mrc_checker.sv
test/testbench.sv
